>>> design/rcsp_pkg.sv
package rcsp_pkg;

  // Character codes seen on the stream
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Field widths
  localparam int unsigned ARG_W   = 20;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned ACC_W   = 36;   // holds limit * 10 + 9
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENTS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENDING     = 2'd2;

  // Configuration reset values
  localparam logic [ARG_W-1:0] RST_MAX_ELEMENTS    = 20'd1024;
  localparam logic [LEN_W-1:0] RST_MAX_BULK_LENGTH = 32'd16777216;
  localparam logic [LEN_W-1:0] RST_MAX_PENDING     = 32'd67108864;

  typedef enum logic [3:0] {
    PH_ARRAY    = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_BULK     = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_CR  = 4'd7,
    PH_DATA_LF  = 4'd8,
    PH_HALT     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_ARG_DONE  = 2'd1,
    KIND_CMD_EMPTY = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_ARRAY_MARKER = 3'd0,
    ERR_BAD_COUNT    = 3'd1,
    ERR_COUNT_LIMIT  = 3'd2,
    ERR_BULK_MARKER  = 3'd3,
    ERR_BAD_LENGTH   = 3'd4,
    ERR_LENGTH_LIMIT = 3'd5,
    ERR_MISSING_CRLF = 3'd6,
    ERR_OVERRUN      = 3'd7
  } err_code_t;

  typedef struct packed {
    logic [ARG_W-1:0] max_elements;
    logic [LEN_W-1:0] max_bulk_length;
    logic [LEN_W-1:0] max_pending;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       payload_byte;
    logic [ARG_W-1:0] arg_number;
    logic             command_done;
    err_code_t        error_code;
  } result_t;

endpackage

>>> design/rcsp_cfg_regs.sv
module rcsp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [rcsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcsp_pkg::LEN_W-1:0]    cfg_data,
  output logic                          cfg_ready,
  output rcsp_pkg::cfg_t                cfg
);
  import rcsp_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_elements    <= RST_MAX_ELEMENTS;
      cfg_r.max_bulk_length <= RST_MAX_BULK_LENGTH;
      cfg_r.max_pending     <= RST_MAX_PENDING;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_ELEMENTS:    cfg_r.max_elements    <= cfg_data[ARG_W-1:0];
        CFG_MAX_BULK_LENGTH: cfg_r.max_bulk_length <= cfg_data;
        CFG_MAX_PENDING:     cfg_r.max_pending     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/rcsp_in_reg.sv
module rcsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_ready,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] byte_q
);

  logic       vld_r;
  logic [7:0] byte_r;

  // Slot is free when empty or drained this cycle
  assign in_ready = !vld_r || take;
  assign byte_vld = vld_r;
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

>>> design/rcsp_core.sv
module rcsp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [7:0]        rx_byte,
  input  rcsp_pkg::cfg_t    cfg,
  output logic              res_en,
  output rcsp_pkg::result_t res
);
  import rcsp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic             seen_r, seen_nxt;
  logic [ARG_W-1:0] elem_r, elem_nxt;
  logic [ARG_W-1:0] arg_r, arg_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] pend_r, pend_nxt;
  logic             err_r, err_nxt;

  logic             is_dig, is_cr, is_lf;
  logic [ACC_W-1:0] acc_ext, acc_mul, limit_ext;
  logic [3:0]       digit;
  logic             over, overrun, active, fail, last_arg;
  err_code_t        fail_code;

  // Byte classes and the next decimal value
  assign is_dig    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_cr     = (rx_byte == CH_CR);
  assign is_lf     = (rx_byte == CH_LF);
  assign digit     = 4'(rx_byte - CH_ZERO);
  assign acc_ext   = {{(ACC_W-LEN_W){1'b0}}, acc_r};
  assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_W-4){1'b0}}, digit};
  assign limit_ext = (phase_r == PH_COUNT)
                   ? {{(ACC_W-ARG_W){1'b0}}, cfg.max_elements}
                   : {{(ACC_W-LEN_W){1'b0}}, cfg.max_bulk_length};
  assign over      = acc_mul > limit_ext;
  assign overrun   = pend_r >= cfg.max_pending;
  assign active    = go && !err_r;
  assign last_arg  = elem_r <= {{(ARG_W-1){1'b0}}, 1'b1};

  // Fault detection and result decode
  always_comb begin
    fail      = 1'b0;
    fail_code = ERR_ARRAY_MARKER;
    res_en    = 1'b0;
    res       = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, arg_number: arg_r,
                  command_done: 1'b0, error_code: ERR_ARRAY_MARKER};
    if (active) begin
      if (overrun) begin
        fail      = 1'b1;
        fail_code = ERR_OVERRUN;
      end else begin
        case (phase_r)
          PH_ARRAY: begin
            if (rx_byte != CH_STAR) begin
              fail      = 1'b1;
              fail_code = ERR_ARRAY_MARKER;
            end
          end
          PH_COUNT: begin
            if (is_dig) begin
              if (over) begin
                fail      = 1'b1;
                fail_code = ERR_COUNT_LIMIT;
              end
            end else if (!(is_cr && seen_r)) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_COUNT;
            end
          end
          PH_COUNT_LF: begin
            if (!is_lf) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_COUNT;
            end else if (acc_r[ARG_W-1:0] == '0) begin
              res_en           = 1'b1;
              res.kind         = KIND_CMD_EMPTY;
              res.arg_number   = '0;
              res.command_done = 1'b1;
            end
          end
          PH_BULK: begin
            if (rx_byte != CH_DOLLAR) begin
              fail      = 1'b1;
              fail_code = ERR_BULK_MARKER;
            end
          end
          PH_LEN: begin
            if (is_dig) begin
              if (over) begin
                fail      = 1'b1;
                fail_code = ERR_LENGTH_LIMIT;
              end
            end else if (!(is_cr && seen_r)) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_LENGTH;
            end
          end
          PH_LEN_LF: begin
            if (!is_lf) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_LENGTH;
            end
          end
          PH_DATA: begin
            res_en           = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
          end
          PH_DATA_CR: begin
            if (!is_cr) begin
              fail      = 1'b1;
              fail_code = ERR_MISSING_CRLF;
            end
          end
          PH_DATA_LF: begin
            if (!is_lf) begin
              fail      = 1'b1;
              fail_code = ERR_MISSING_CRLF;
            end else begin
              res_en           = 1'b1;
              res.kind         = KIND_ARG_DONE;
              res.command_done = last_arg;
            end
          end
          default: ;
        endcase
      end
      if (fail) begin
        res_en         = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = fail_code;
      end
    end
  end

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      if (fail) begin
        phase_nxt = PH_HALT;
      end else begin
        case (phase_r)
          PH_ARRAY:    phase_nxt = PH_COUNT;
          PH_COUNT:    if (is_cr) phase_nxt = PH_COUNT_LF;
          PH_COUNT_LF: phase_nxt = (acc_r[ARG_W-1:0] == '0) ? PH_ARRAY : PH_BULK;
          PH_BULK:     phase_nxt = PH_LEN;
          PH_LEN:      if (is_cr) phase_nxt = PH_LEN_LF;
          PH_LEN_LF:   phase_nxt = (acc_r == '0) ? PH_DATA_CR : PH_DATA;
          PH_DATA:     if (left_r == {{(LEN_W-1){1'b0}}, 1'b1}) phase_nxt = PH_DATA_CR;
          PH_DATA_CR:  phase_nxt = PH_DATA_LF;
          PH_DATA_LF:  phase_nxt = last_arg ? PH_ARRAY : PH_BULK;
          default:     phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Counters and accumulator
  always_comb begin
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    elem_nxt = elem_r;
    arg_nxt  = arg_r;
    left_nxt = left_r;
    pend_nxt = pend_r;
    err_nxt  = err_r;
    if (active) begin
      if (fail) begin
        err_nxt = 1'b1;
      end else begin
        pend_nxt = pend_r + 1'b1;
        case (phase_r)
          PH_ARRAY, PH_BULK: begin
            acc_nxt  = '0;
            seen_nxt = 1'b0;
          end
          PH_COUNT, PH_LEN: begin
            if (is_dig) begin
              acc_nxt  = acc_mul[LEN_W-1:0];
              seen_nxt = 1'b1;
            end
          end
          PH_COUNT_LF: begin
            elem_nxt = acc_r[ARG_W-1:0];
            arg_nxt  = '0;
            if (acc_r[ARG_W-1:0] == '0) pend_nxt = '0;
          end
          PH_LEN_LF: left_nxt = acc_r;
          PH_DATA:   left_nxt = left_r - 1'b1;
          PH_DATA_LF: begin
            if (last_arg) begin
              elem_nxt = '0;
              arg_nxt  = '0;
              pend_nxt = '0;
            end else begin
              elem_nxt = elem_r - 1'b1;
              arg_nxt  = arg_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ARRAY;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      elem_r  <= '0;
      arg_r   <= '0;
      left_r  <= '0;
      pend_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      elem_r  <= elem_nxt;
      arg_r   <= arg_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

>>> design/rcsp_out_reg.sv
module rcsp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_en,
  input  rcsp_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              slot_free,
  output rcsp_pkg::result_t res_q
);
  import rcsp_pkg::*;

  logic    vld_r;
  result_t res_r;

  assign slot_free = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign res_q     = res_r;

  // Result register: reloaded on every core step, drained by out_ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= res_en;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_en) begin
      res_r <= res;
    end
  end

endmodule

>>> design/resp_command_stream_parser.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_rx_byte
// out_      output     out_valid/out_ready  kind, payload_byte, arg_number,
//                                           command_done, error_code
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready keeps the result register draining: a
// request is held in the input register, is parsed by the core and lands in the result
// register. cfg_ready is always high.
// Synchronous active-low reset restores limits and the parser state.
// A stalled result register holds the core and, through it, the input side.
module resp_command_stream_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_payload_byte,
  output logic [rcsp_pkg::ARG_W-1:0]     out_arg_number,
  output logic                           out_command_done,
  output logic [2:0]                     out_error_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcsp_pkg::LEN_W-1:0]     cfg_data
);
  import rcsp_pkg::*;

  cfg_t       cfg;
  logic       byte_vld, slot_free, go, res_en;
  logic [7:0] byte_q;
  result_t    res, res_q;

  // Core steps when a byte is held and the result slot can take it
  assign go = byte_vld && slot_free;

  rcsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  rcsp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_ready   (in_ready),
    .take       (go),
    .byte_vld   (byte_vld),
    .byte_q     (byte_q)
  );

  rcsp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .rx_byte (byte_q),
    .cfg     (cfg),
    .res_en  (res_en),
    .res     (res)
  );

  rcsp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .res_en    (res_en),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .res_q     (res_q)
  );

  assign out_kind         = res_q.kind;
  assign out_payload_byte = res_q.payload_byte;
  assign out_arg_number   = res_q.arg_number;
  assign out_command_done = res_q.command_done;
  assign out_error_code   = res_q.error_code;

endmodule

>>> tb/resp_command_stream_parser_test.sv
module resp_command_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcsp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Ways to spoil a decimal number line
  typedef enum int unsigned {
    FLAW_NO_DIGIT,
    FLAW_STRAY_CHAR,
    FLAW_NO_LF
  } flaw_t;

  // Receiver stall patterns
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SLOW,
    RX_MOSTLY
  } rx_mode_t;

  // Parser predictor and store of due results
  class resp_scoreboard;
    logic [ARG_W-1:0] lim_elements;
    logic [LEN_W-1:0] lim_bulk;
    logic [LEN_W-1:0] lim_pending;
    phase_t           phase;
    logic [63:0]      accum;
    bit               have_digit;
    bit               halted;
    logic [ARG_W-1:0] elems_left;
    logic [ARG_W-1:0] arg_idx;
    logic [LEN_W-1:0] bytes_left;
    logic [LEN_W-1:0] cmd_bytes;
    result_t          due_results[$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    function new();
      lim_elements = RST_MAX_ELEMENTS;
      lim_bulk     = RST_MAX_BULK_LENGTH;
      lim_pending  = RST_MAX_PENDING;
      phase        = PH_ARRAY;
      accum        = '0;
      have_digit   = 1'b0;
      halted       = 1'b0;
      elems_left   = '0;
      arg_idx      = '0;
      bytes_left   = '0;
      cmd_bytes    = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      case (idx)
        CFG_MAX_ELEMENTS:    lim_elements = data[ARG_W-1:0];
        CFG_MAX_BULK_LENGTH: lim_bulk = data;
        CFG_MAX_PENDING:     lim_pending = data;
        default: ;
      endcase
    endfunction

    function void push_result(kind_t kind, logic [7:0] data, logic done);
      result_t r;
      r = '0;
      r.kind         = kind;
      r.payload_byte = data;
      r.arg_number   = arg_idx;
      r.command_done = done;
      due_results.insert(due_results.size(), r);
    endfunction

    // Any fault reports once and then the parser goes deaf
    function void latch_error(err_code_t code);
      halted = 1'b1;
      phase  = PH_HALT;
      push_result(KIND_ERROR, 8'h00, 1'b0);
      due_results[$].error_code = code;
    endfunction

    // Returns 1 once the value passes the limit
    function bit take_digit(logic [7:0] b, logic [LEN_W-1:0] limit);
      accum      = accum * 10 + 64'(b - CH_ZERO);
      have_digit = 1'b1;
      return accum > 64'(limit);
    endfunction

    function void parse_byte(logic [7:0] b);
      bit is_digit;
      bit last;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      if (halted) return;
      if (cmd_bytes >= lim_pending) begin
        latch_error(ERR_OVERRUN);
        return;
      end
      cmd_bytes++;
      case (phase)
        PH_ARRAY: begin
          if (b != CH_STAR) latch_error(ERR_ARRAY_MARKER);
          else begin
            accum      = '0;
            have_digit = 1'b0;
            phase      = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (is_digit) begin
            if (take_digit(b, LEN_W'(lim_elements))) latch_error(ERR_COUNT_LIMIT);
          end else if (b == CH_CR && have_digit) phase = PH_COUNT_LF;
          else latch_error(ERR_BAD_COUNT);
        end
        PH_COUNT_LF: begin
          if (b != CH_LF) latch_error(ERR_BAD_COUNT);
          else begin
            elems_left = accum[ARG_W-1:0];
            arg_idx    = '0;
            if (elems_left == '0) begin
              cmd_bytes = '0;
              phase     = PH_ARRAY;
              push_result(KIND_CMD_EMPTY, 8'h00, 1'b1);
            end else phase = PH_BULK;
          end
        end
        PH_BULK: begin
          if (b != CH_DOLLAR) latch_error(ERR_BULK_MARKER);
          else begin
            accum      = '0;
            have_digit = 1'b0;
            phase      = PH_LEN;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            if (take_digit(b, lim_bulk)) latch_error(ERR_LENGTH_LIMIT);
          end else if (b == CH_CR && have_digit) phase = PH_LEN_LF;
          else latch_error(ERR_BAD_LENGTH);
        end
        PH_LEN_LF: begin
          if (b != CH_LF) latch_error(ERR_BAD_LENGTH);
          else begin
            bytes_left = accum[LEN_W-1:0];
            phase      = (bytes_left != '0) ? PH_DATA : PH_DATA_CR;
          end
        end
        PH_DATA: begin
          bytes_left--;
          if (bytes_left == '0) phase = PH_DATA_CR;
          push_result(KIND_PAYLOAD, b, 1'b0);
        end
        PH_DATA_CR: begin
          if (b != CH_CR) latch_error(ERR_MISSING_CRLF);
          else phase = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (b != CH_LF) latch_error(ERR_MISSING_CRLF);
          else begin
            last = (elems_left <= 1);
            push_result(KIND_ARG_DONE, 8'h00, last);
            if (last) begin
              elems_left = '0;
              arg_idx    = '0;
              cmd_bytes  = '0;
              phase      = PH_ARRAY;
            end else begin
              elems_left--;
              arg_idx++;
              phase = PH_BULK;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t ns: result with none due: kind %0d byte %0d arg %0d done %0d code %0d",
                 $time, got.kind, got.payload_byte, got.arg_number, got.command_done,
                 got.error_code);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("payload_byte", want.payload_byte, got.payload_byte);
      compare("arg_number", want.arg_number, got.arg_number);
      compare("command_done", want.command_done, got.command_done);
      compare("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_kind;
  logic [7:0]           out_payload_byte;
  logic [ARG_W-1:0]     out_arg_number;
  logic                 out_command_done;
  logic [2:0]           out_error_code;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;

  resp_scoreboard sb;
  int unsigned    bytes_sent;
  int unsigned    burst_left;

  resp_command_stream_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_arg_number   (out_arg_number),
    .out_command_done (out_command_done),
    .out_error_code   (out_error_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("resp_command_stream_parser_test: FAIL");
    $finish;
  end

  // Collect accepted results
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind         = kind_t'(out_kind);
      got.payload_byte = out_payload_byte;
      got.arg_number   = out_arg_number;
      got.command_done = out_command_done;
      got.error_code   = err_code_t'(out_error_code);
      sb.check_result(got);
    end
  end

  // Receiver: changing stall patterns plus one long hold-off
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    bit          held;
    mode      = RX_OPEN;
    mode_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (!held && sb.results_seen >= 150) begin
        // long stall while the sender keeps offering: fills the pipe
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        case (mode)
          RX_OPEN:  out_ready <= 1'b1;
          RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
          RX_SLOW:  out_ready <= ($urandom_range(0, 9) == 0);
          default:  out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // One request on the input channel, with bursty gaps
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) push_byte(q[i]);
  endtask

  // Stop sending, let every due result arrive, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic set_limits(input logic [ARG_W-1:0] elems, input logic [LEN_W-1:0] bulk,
                            input logic [LEN_W-1:0] pend);
    write_reg(CFG_MAX_ELEMENTS, LEN_W'(elems));
    write_reg(CFG_MAX_BULK_LENGTH, bulk);
    write_reg(CFG_MAX_PENDING, pend);
    cfg_valid <= 1'b0;
  endtask

  // Append one byte to the end of a stream
  function automatic void put_byte(ref byte_q_t q, input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void append_crlf(ref byte_q_t q);
    put_byte(q, CH_CR);
    put_byte(q, CH_LF);
  endfunction

  // Decimal digits, now and then with leading zeros
  function automatic void append_number(ref byte_q_t q, input longint unsigned v);
    string       s;
    int unsigned zeros;
    s = $sformatf("%0d", v);
    zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) put_byte(q, CH_ZERO);
    for (int i = 0; i < s.len(); i++) put_byte(q, 8'(s[i]));
  endfunction

  // Payload leans on the framing characters to prove they pass through
  function automatic logic [7:0] payload_pick();
    case ($urandom_range(0, 11))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_STAR;
      3:       return CH_DOLLAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void append_argument(ref byte_q_t q, input int unsigned max_len);
    int unsigned len;
    if (max_len == 0) len = 0;
    else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, max_len);
    else len = $urandom_range(0, (max_len < 8) ? max_len : 8);
    put_byte(q, CH_DOLLAR);
    append_number(q, len);
    append_crlf(q);
    repeat (len) put_byte(q, payload_pick());
    append_crlf(q);
  endfunction

  function automatic void build_command(ref byte_q_t q, input int unsigned n_args,
                                        input int unsigned max_len);
    put_byte(q, CH_STAR);
    append_number(q, n_args);
    append_crlf(q);
    repeat (n_args) append_argument(q, max_len);
  endfunction

  function automatic void append_bad_number(ref byte_q_t q, input flaw_t flaw);
    logic [7:0] b;
    case (flaw)
      FLAW_NO_DIGIT: put_byte(q, CH_CR);
      FLAW_STRAY_CHAR: begin
        if ($urandom_range(0, 1) != 0) append_number(q, $urandom_range(0, 3));
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR);
        put_byte(q, b);
      end
      default: begin
        append_number(q, $urandom_range(0, 3));
        put_byte(q, CH_CR);
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
        put_byte(q, b);
      end
    endcase
  endfunction

  // Closing phase: one fault of a random kind, then bytes that must be ignored
  task automatic run_fault_phase();
    byte_q_t          q;
    err_code_t        which;
    flaw_t            flaw;
    logic [7:0]       b;
    int unsigned      pick;
    logic [ARG_W-1:0] e_lim;
    logic [LEN_W-1:0] b_lim;
    logic [LEN_W-1:0] p_lim;
    which = err_code_t'($urandom_range(0, 7));
    flaw  = flaw_t'($urandom_range(0, 2));
    pick  = $urandom_range(0, 2);
    q = {};
    case (which)
      ERR_ARRAY_MARKER: begin
        set_limits(ARG_W'(4), 32'd16, '1);
        build_command(q, $urandom_range(0, 4), 16);
        do b = 8'($urandom_range(0, 255)); while (b == CH_STAR);
        put_byte(q, b);
      end
      ERR_BAD_COUNT: begin
        set_limits(ARG_W'(4), 32'd16, '1);
        put_byte(q, CH_STAR);
        append_bad_number(q, flaw);
      end
      ERR_COUNT_LIMIT: begin
        e_lim = (pick == 0) ? '1 : ARG_W'($urandom_range(0, 50));
        set_limits(e_lim, 32'd16, '1);
        put_byte(q, CH_STAR);
        append_number(q, 64'(e_lim) + 64'($urandom_range(1, 5000)));
        append_crlf(q);
      end
      ERR_BULK_MARKER: begin
        set_limits(ARG_W'(4), 32'd16, '1);
        put_byte(q, CH_STAR);
        append_number(q, 2 + pick);
        append_crlf(q);
        if (pick != 0) append_argument(q, 16);
        do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR);
        put_byte(q, b);
      end
      ERR_BAD_LENGTH: begin
        set_limits(ARG_W'(4), 32'd16, '1);
        put_byte(q, CH_STAR);
        append_number(q, $urandom_range(1, 4));
        append_crlf(q);
        put_byte(q, CH_DOLLAR);
        append_bad_number(q, flaw);
      end
      ERR_LENGTH_LIMIT: begin
        b_lim = (pick == 0) ? '1 : LEN_W'($urandom_range(0, 100));
        set_limits(ARG_W'(4), b_lim, '1);
        put_byte(q, CH_STAR);
        append_number(q, 1);
        append_crlf(q);
        put_byte(q, CH_DOLLAR);
        append_number(q, 64'(b_lim) + 64'($urandom_range(1, 5000)));
        append_crlf(q);
      end
      ERR_MISSING_CRLF: begin
        set_limits(ARG_W'(4), 32'd16, '1);
        put_byte(q, CH_STAR);
        append_number(q, 1);
        append_crlf(q);
        put_byte(q, CH_DOLLAR);
        append_number(q, pick * 2);
        append_crlf(q);
        repeat (pick * 2) put_byte(q, payload_pick());
        if ($urandom_range(0, 1) == 0) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
        end else begin
          put_byte(q, CH_CR);
          do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
        end
        put_byte(q, b);
      end
      default: begin
        // overrun: the command is longer than the pending limit allows
        build_command(q, $urandom_range(1, 4), 16);
        p_lim = (pick == 0) ? LEN_W'(1) : LEN_W'($urandom_range(1, q.size() - 1));
        set_limits(ARG_W'(4), 32'd16, p_lim);
      end
    endcase
    repeat (12) put_byte(q, 8'($urandom_range(0, 255)));
    send_bytes(q);
    drain();
  endtask

  initial begin : stimulus
    byte_q_t     q;
    int unsigned goal;
    int unsigned n;
    int unsigned mlen;
    logic [ARG_W-1:0] e_lim;
    logic [LEN_W-1:0] b_lim;
    sb = new();
    bytes_sent = 0;
    burst_left = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_MAX_ELEMENTS;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset limits: empty command, leading zeros, empty and 0xFF argument
    q = {};
    put_byte(q, CH_STAR);
    put_byte(q, CH_ZERO);
    append_crlf(q);
    put_byte(q, CH_STAR);
    put_byte(q, CH_ZERO);
    put_byte(q, CH_ZERO);
    put_byte(q, CH_ZERO + 8'd2);
    append_crlf(q);
    put_byte(q, CH_DOLLAR);
    put_byte(q, CH_ZERO);
    append_crlf(q);
    append_crlf(q);
    put_byte(q, CH_DOLLAR);
    put_byte(q, CH_ZERO + 8'd1);
    append_crlf(q);
    put_byte(q, 8'hFF);
    append_crlf(q);
    send_bytes(q);
    drain();

    // Widest limits, mixed commands
    set_limits('1, '1, '1);
    goal = bytes_sent + 700;
    while (bytes_sent < goal) begin
      q = {};
      build_command(q, $urandom_range(0, 6), 64);
      send_bytes(q);
    end
    drain();

    // No elements allowed: only empty commands get through
    set_limits('0, '0, '1);
    repeat (15) begin
      q = {};
      build_command(q, 0, 0);
      send_bytes(q);
    end
    drain();

    // Zero-length arguments only, counts up to the limit
    set_limits(ARG_W'(3), '0, '1);
    goal = bytes_sent + 300;
    while (bytes_sent < goal) begin
      q = {};
      build_command(q, $urandom_range(1, 3), 0);
      send_bytes(q);
    end
    drain();

    // Small random limits
    e_lim = ARG_W'($urandom_range(1, 8));
    b_lim = LEN_W'($urandom_range(1, 40));
    set_limits(e_lim, b_lim, '1);
    goal = bytes_sent + 700;
    while (bytes_sent < goal) begin
      q = {};
      build_command(q, $urandom_range(0, int'(e_lim)), int'(b_lim));
      send_bytes(q);
    end
    drain();

    // Each command meets its element and pending limits exactly, lengths within the bulk limit
    repeat (12) begin
      n    = $urandom_range(1, 5);
      mlen = $urandom_range(1, 12);
      q = {};
      build_command(q, n, mlen);
      set_limits(ARG_W'(n), LEN_W'(mlen), LEN_W'(q.size()));
      send_bytes(q);
      drain();
    end

    run_fault_phase();

    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("resp_command_stream_parser_test: PASS");
    else
      $display("resp_command_stream_parser_test: FAIL");
    $finish;
  end

endmodule
